[design/ntc_pkg.sv]
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared constants and controller/datapath interface types for the
// nearest-template classifier.
// ----------------------------------------------------------------------------
package ntc_pkg;

  // Storage sizes
  localparam int unsigned MAX_TEMPLATES  = 64;
  localparam int unsigned FEATURE_LENGTH = 64;

  // Field widths
  localparam int unsigned TIDX_W   = 6;
  localparam int unsigned EIDX_W   = 6;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LABEL_W  = 8;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned DIST_W   = 38;
  localparam int unsigned SQ_W     = 2 * SAMPLE_W;
  localparam int unsigned TADDR_W  = TIDX_W + EIDX_W;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              load_wr;      // write one template element and its label
    logic              query_start;  // latch query element, reset the search
    logic              issue;        // start one template through the pipeline
    logic [TIDX_W-1:0] issue_idx;    // template issued this cycle
    logic              label_rd;     // fetch the label of the best template
    logic              out_load;     // load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic busy;      // some template still in the pipeline
    logic out_free;  // result register can take a new beat
  } dp_status_t;

endpackage

[design/nearest_template_classifier_top.sv]
// One-nearest-neighbor classifier over up to 64 stored templates of 64 unsigned
// Q0.16 elements, squared Euclidean distance. A load beat (operation 0) writes
// one template element and the template's label. A query beat (operation 1)
// carries one feature element; element index 0 restarts all distance sums.
// During a query beat the distance memory updates one of the N active
// templates per cycle through a three-stage read, square, accumulate pipeline
// that drains before the next beat is taken; a beat with last_element set then
// also fetches the label and, once the previous result has left the output
// register, loads the result. Sums saturate at 2^38-1.
// ----------------------------------------------------------------------------
// nearest_template_classifier_top
// Top level: joins the controller and the datapath.
// ----------------------------------------------------------------------------
module nearest_template_classifier_top import ntc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [COUNT_W-1:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [TIDX_W-1:0]   template_index_i,
  input  logic [EIDX_W-1:0]   element_index_i,
  input  logic [SAMPLE_W-1:0] sample_value_i,
  input  logic [LABEL_W-1:0]  class_label_i,
  input  logic                last_element_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                found_o,
  output logic [LABEL_W-1:0]  best_label_o,
  output logic [TIDX_W-1:0]   best_index_o,
  output logic [DIST_W-1:0]   best_distance_o
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  ntc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .last_element_i (last_element_i),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  ntc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .template_index_i (template_index_i),
    .element_index_i  (element_index_i),
    .sample_value_i   (sample_value_i),
    .class_label_i    (class_label_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .found_o          (found_o),
    .best_label_o     (best_label_o),
    .best_index_o     (best_index_o),
    .best_distance_o  (best_distance_o)
  );

`ifndef ASSERT_OFF
  // No new beat is taken while templates are still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_stall_o |-> !status.busy)
    else $error("input taken while pipeline busy");

  // The sweep only runs while the input side is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.issue |-> in_stall_o)
    else $error("template issued while input open");

  // A result is loaded only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.out_load |-> status.out_free)
    else $error("result overwrote a pending beat");

  // A not-found result carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (best_index_o == '0 && best_distance_o == '0))
    else $error("not-found result with nonzero fields");
`endif

endmodule

[design/ntc_datapath.sv]
// ----------------------------------------------------------------------------
// ntc_datapath
// Template, label and distance memories, the squared-difference pipeline with
// saturating accumulation, the running minimum and the result register.
// ----------------------------------------------------------------------------
module ntc_datapath import ntc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_cmd_t            cmd_i,
  output dp_status_t          status_o,
  input  logic [TIDX_W-1:0]   template_index_i,
  input  logic [EIDX_W-1:0]   element_index_i,
  input  logic [SAMPLE_W-1:0] sample_value_i,
  input  logic [LABEL_W-1:0]  class_label_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                found_o,
  output logic [LABEL_W-1:0]  best_label_o,
  output logic [TIDX_W-1:0]   best_index_o,
  output logic [DIST_W-1:0]   best_distance_o
);

  // Memories
  logic [SAMPLE_W-1:0] tmpl_mem [MAX_TEMPLATES*FEATURE_LENGTH];
  logic [LABEL_W-1:0]  label_mem [MAX_TEMPLATES];
  logic [DIST_W-1:0]   dist_mem [MAX_TEMPLATES];
  logic [MAX_TEMPLATES-1:0] dvalid_q;

  // Latched query element
  logic [EIDX_W-1:0]   eix_q;
  logic [SAMPLE_W-1:0] val_q;
  logic                en_q;

  // Pipeline stage 1: memory reads
  logic                s1_vld_q;
  logic [TIDX_W-1:0]   s1_idx_q;
  logic [SAMPLE_W-1:0] s1_tmpl_q;
  logic [DIST_W-1:0]   s1_dist_q;
  logic                s1_dvld_q;

  // Pipeline stage 2: squared difference
  logic                s2_vld_q;
  logic [TIDX_W-1:0]   s2_idx_q;
  logic [SQ_W-1:0]     s2_sq_q;
  logic [DIST_W-1:0]   s2_acc_q;

  // Pipeline stage 3: updated sum
  logic                s3_vld_q;
  logic [TIDX_W-1:0]   s3_idx_q;
  logic [DIST_W-1:0]   s3_sum_q;

  // Running minimum and label
  logic                found_q;
  logic [TIDX_W-1:0]   best_idx_q;
  logic [DIST_W-1:0]   best_dist_q;
  logic [LABEL_W-1:0]  lbl_q;

  // Result register
  logic                out_valid_q;
  logic                found_out_q;
  logic [LABEL_W-1:0]  label_out_q;
  logic [TIDX_W-1:0]   index_out_q;
  logic [DIST_W-1:0]   dist_out_q;

  logic                load_ok;
  logic [TADDR_W-1:0]  load_addr;
  logic [TADDR_W-1:0]  rd_addr;
  logic [SAMPLE_W-1:0] abs_diff;
  logic [DIST_W:0]     sum_wide;
  logic [DIST_W-1:0]   sum_sat;
  logic                take_min;

  // Decode load range and addresses
  assign load_ok = cmd_i.load_wr
                   && ({1'b0, template_index_i} < (TIDX_W+1)'(MAX_TEMPLATES))
                   && ({1'b0, element_index_i} < (EIDX_W+1)'(FEATURE_LENGTH));
  assign load_addr = {template_index_i, element_index_i};
  assign rd_addr   = {cmd_i.issue_idx, eix_q};

  // Write templates and labels on load beats
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      tmpl_mem[load_addr]         <= sample_value_i;
      label_mem[template_index_i] <= class_label_i;
    end
  end

  // Latch the query element
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      eix_q <= element_index_i;
      val_q <= sample_value_i;
      en_q  <= ({1'b0, element_index_i} < (EIDX_W+1)'(FEATURE_LENGTH));
    end
  end

  // Read template element and accumulator
  always_ff @(posedge clk_i) begin
    s1_tmpl_q <= tmpl_mem[rd_addr];
    s1_dist_q <= dist_mem[cmd_i.issue_idx];
    s1_dvld_q <= dvalid_q[cmd_i.issue_idx];
    s1_idx_q  <= cmd_i.issue_idx;
  end

  // Square the difference; gate when the element is out of range
  assign abs_diff = (s1_tmpl_q > val_q) ? (s1_tmpl_q - val_q) : (val_q - s1_tmpl_q);

  always_ff @(posedge clk_i) begin
    s2_sq_q  <= en_q ? (SQ_W'(abs_diff) * SQ_W'(abs_diff)) : '0;
    s2_acc_q <= s1_dvld_q ? s1_dist_q : '0;
    s2_idx_q <= s1_idx_q;
  end

  // Accumulate with saturation and write back
  assign sum_wide = {1'b0, s2_acc_q} + (DIST_W+1)'(s2_sq_q);
  assign sum_sat  = sum_wide[DIST_W] ? {DIST_W{1'b1}} : sum_wide[DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      dist_mem[s2_idx_q] <= sum_sat;
    end
    s3_sum_q <= sum_sat;
    s3_idx_q <= s2_idx_q;
  end

  // Track pipeline occupancy and accumulator valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      dvalid_q <= '0;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      if (cmd_i.query_start && (element_index_i == '0)) begin
        dvalid_q <= '0;
      end else if (s2_vld_q) begin
        dvalid_q[s2_idx_q] <= 1'b1;
      end
    end
  end

  // Keep the running minimum; strict compare keeps the lowest index on ties
  assign take_min = s3_vld_q && (!found_q || (s3_sum_q < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.query_start) begin
      found_q <= 1'b0;
    end else if (take_min) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_min) begin
      best_idx_q  <= s3_idx_q;
      best_dist_q <= s3_sum_q;
    end
  end

  // Fetch the label of the winner
  always_ff @(posedge clk_i) begin
    if (cmd_i.label_rd) begin
      lbl_q <= label_mem[best_idx_q];
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      found_out_q <= found_q;
      label_out_q <= found_q ? lbl_q : '0;
      index_out_q <= found_q ? best_idx_q : '0;
      dist_out_q  <= found_q ? best_dist_q : '0;
    end
  end

  assign status_o.busy     = s1_vld_q | s2_vld_q | s3_vld_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_out_q;
  assign best_label_o    = label_out_q;
  assign best_index_o    = index_out_q;
  assign best_distance_o = dist_out_q;

endmodule

[design/ntc_ctrl.sv]
// ----------------------------------------------------------------------------
// ntc_ctrl
// Controller: holds the template count, takes input beats, sweeps the active
// templates once per query element and sequences the result.
// ----------------------------------------------------------------------------
module ntc_ctrl import ntc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic               last_element_i,
  output ctl_cmd_t           cmd_o,
  input  dp_status_t         status_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_LABEL = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [TIDX_W-1:0]  idx_q, idx_d;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] active_q, active_d;
  logic               last_q, last_d;
  logic [COUNT_W-1:0] n_eff;
  logic               accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Clamp the count to the store size
  assign n_eff = (count_q > COUNT_W'(MAX_TEMPLATES)) ? COUNT_W'(MAX_TEMPLATES) : count_q;

  // Template count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    active_d = active_q;
    last_d   = last_q;
    cmd_o    = '0;
    cmd_o.issue_idx = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_LOAD)) begin
          cmd_o.load_wr = 1'b1;
        end
        if (accept && (operation_i == OP_QUERY)) begin
          cmd_o.query_start = 1'b1;
          last_d   = last_element_i;
          active_d = n_eff;
          idx_d    = '0;
          state_d  = (n_eff == '0) ? ST_DRAIN : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.issue = 1'b1;
        if (COUNT_W'(idx_q) == (active_q - COUNT_W'(1))) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + TIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = last_q ? ST_LABEL : ST_IDLE;
        end
      end
      ST_LABEL: begin
        cmd_o.label_rd = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      active_q <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      active_q <= active_d;
      last_q   <= last_d;
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-template classifier. Directed beats hit
// empty search, extreme samples, ties, count clamping, count changes inside a
// query and distance saturation; random load and query sequences follow under
// three idling patterns. A bench-side model predicts every result.
// ----------------------------------------------------------------------------
module testbench import ntc_pkg::*;;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned REPORT_MAX     = 10;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic               found;
    logic [LABEL_W-1:0] label;
    logic [TIDX_W-1:0]  index;
    logic [DIST_W-1:0]  distance;
  } nearest_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [COUNT_W-1:0]  cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                operation_i;
  logic [TIDX_W-1:0]   template_index_i;
  logic [EIDX_W-1:0]   element_index_i;
  logic [SAMPLE_W-1:0] sample_value_i;
  logic [LABEL_W-1:0]  class_label_i;
  logic                last_element_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                found_o;
  logic [LABEL_W-1:0]  best_label_o;
  logic [TIDX_W-1:0]   best_index_o;
  logic [DIST_W-1:0]   best_distance_o;

  // Bench-side copy of the classifier state
  logic [SAMPLE_W-1:0] template_mem [MAX_TEMPLATES][FEATURE_LENGTH];
  logic [LABEL_W-1:0]  label_mem    [MAX_TEMPLATES];
  logic [DIST_W-1:0]   distance_acc [MAX_TEMPLATES];
  bit                  element_loaded [MAX_TEMPLATES][FEATURE_LENGTH];
  logic [COUNT_W-1:0]  template_count;
  nearest_t            nearest_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          narrow_values;
  int unsigned beats_sent;
  int unsigned load_beats;
  int unsigned query_beats;
  int unsigned empty_results;
  int unsigned saturated_results;
  int unsigned count_writes;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  nearest_template_classifier_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .template_index_i (template_index_i),
    .element_index_i  (element_index_i),
    .sample_value_i   (sample_value_i),
    .class_label_i    (class_label_i),
    .last_element_i   (last_element_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .found_o          (found_o),
    .best_label_o     (best_label_o),
    .best_index_o     (best_index_o),
    .best_distance_o  (best_distance_o)
  );

  always #10 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Abort when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned active_templates();
    return (template_count > MAX_TEMPLATES) ? MAX_TEMPLATES : template_count;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    if (!narrow_values) return SAMPLE_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'h0001;
      2:       return 16'h8000;
      default: return '1;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 10) return COUNT_W'(MAX_TEMPLATES);
    if (r < 15) return COUNT_W'($urandom_range(65, 127));
    if (r < 20) return COUNT_W'($urandom_range(17, 63));
    return COUNT_W'($urandom_range(1, 16));
  endfunction

  // Update the bench state for one accepted beat and queue any nearest match
  function automatic void classify_beat(input logic op, input logic [TIDX_W-1:0] tix,
                                        input logic [EIDX_W-1:0] eix,
                                        input logic [SAMPLE_W-1:0] value,
                                        input logic [LABEL_W-1:0] label,
                                        input logic last);
    int unsigned         n;
    logic [SAMPLE_W-1:0] diff;
    logic [DIST_W:0]     total;
    nearest_t            best;
    n = active_templates();
    if (op == OP_LOAD) begin
      template_mem[tix][eix]   = value;
      label_mem[tix]           = label;
      element_loaded[tix][eix] = 1'b1;
      load_beats++;
      return;
    end
    query_beats++;
    if (eix == 0) begin
      foreach (distance_acc[i]) distance_acc[i] = '0;
    end
    for (int unsigned i = 0; i < n; i++) begin
      diff = (template_mem[i][eix] > value) ? template_mem[i][eix] - value
                                            : value - template_mem[i][eix];
      total = {1'b0, distance_acc[i]} + ((DIST_W+1)'(diff) * (DIST_W+1)'(diff));
      distance_acc[i] = (total > {1'b0, DIST_MAX}) ? DIST_MAX : total[DIST_W-1:0];
    end
    if (!last) return;
    best = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!best.found || distance_acc[i] < best.distance) begin
        best.found    = 1'b1;
        best.label    = label_mem[i];
        best.index    = TIDX_W'(i);
        best.distance = distance_acc[i];
      end
    end
    if (!best.found) empty_results++;
    if (best.found && best.distance == DIST_MAX) saturated_results++;
    nearest_q.push_back(best);
  endfunction

  // Drive one beat from a falling edge and hold it until accepted. Returns on
  // the next falling edge with valid still high; the caller drives or drops it
  // in that same step.
  task automatic send_beat(input logic op, input logic [TIDX_W-1:0] tix,
                           input logic [EIDX_W-1:0] eix, input logic [SAMPLE_W-1:0] value,
                           input logic [LABEL_W-1:0] label, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    template_index_i <= tix;
    element_index_i  <= eix;
    sample_value_i   <= value;
    class_label_i    <= label;
    last_element_i   <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    classify_beat(op, tix, eix, value, label, last);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_element(input logic [TIDX_W-1:0] tix, input logic [EIDX_W-1:0] eix,
                              input logic [SAMPLE_W-1:0] value,
                              input logic [LABEL_W-1:0] label);
    send_beat(OP_LOAD, tix, eix, value, label, 1'($urandom));
  endtask

  // Query one feature element; back-fill any active template lacking this
  // element first so that no empty entry is ever read
  task automatic query_element(input logic [EIDX_W-1:0] eix,
                               input logic [SAMPLE_W-1:0] value, input logic last);
    int unsigned n;
    n = active_templates();
    for (int unsigned t = 0; t < n; t++) begin
      if (!element_loaded[t][eix]) load_element(TIDX_W'(t), eix, pick_sample(), 8'($urandom));
    end
    send_beat(OP_QUERY, TIDX_W'($urandom), eix, value, 8'($urandom), last);
  endtask

  // Wait for the block to go idle, then write the template count
  task automatic set_template_count(input logic [COUNT_W-1:0] value);
    in_valid_i <= 1'b0;
    while (nearest_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    template_count = value;
    count_writes++;
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    nearest_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (nearest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with none expected: found=%0b label=%0h index=%0d dist=%0d",
                   $realtime, found_o, best_label_o, best_index_o, best_distance_o);
      end else begin
        want = nearest_q.pop_front();
        if (found_o !== want.found || best_label_o !== want.label ||
            best_index_o !== want.index || best_distance_o !== want.distance) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: mismatch exp found=%0b label=%0h index=%0d dist=%0d / got %0b %0h %0d %0d",
                     $realtime, want.found, want.label, want.index, want.distance,
                     found_o, best_label_o, best_index_o, best_distance_o);
        end
      end
    end
  end

  // Search with no active template, and a last flag on a load
  task automatic test_no_templates();
    query_element(6'd0, 16'hFFFF, 1'b1);
    send_beat(OP_LOAD, 6'd5, 6'd0, 16'h1234, 8'h5A, 1'b1);
    query_element(6'd63, 16'h0000, 1'b1);
  endtask

  // Extreme samples, labels and element positions
  task automatic test_extremes();
    set_template_count(7'd2);
    send_beat(OP_LOAD, 6'd0, 6'd0, 16'h0000, 8'h00, 1'b0);
    send_beat(OP_LOAD, 6'd1, 6'd0, 16'hFFFF, 8'hFF, 1'b1);
    query_element(6'd0, 16'hFFFF, 1'b1);
    query_element(6'd0, 16'h0000, 1'b1);
    query_element(6'd0, 16'h8000, 1'b1);
    send_beat(OP_LOAD, 6'd0, 6'd63, 16'hFFFF, 8'h00, 1'b1);
    send_beat(OP_LOAD, 6'd1, 6'd63, 16'h0000, 8'hFF, 1'b0);
    query_element(6'd0, 16'h0000, 1'b0);
    query_element(6'd63, 16'h0000, 1'b1);
  endtask

  // Equal distances go to the lowest index
  task automatic test_ties();
    set_template_count(7'd3);
    send_beat(OP_LOAD, 6'd0, 6'd0, 16'd100, 8'h11, 1'b0);
    send_beat(OP_LOAD, 6'd1, 6'd0, 16'd100, 8'h22, 1'b0);
    send_beat(OP_LOAD, 6'd2, 6'd0, 16'd300, 8'h33, 1'b0);
    query_element(6'd0, 16'd100, 1'b1);
    send_beat(OP_LOAD, 6'd0, 6'd0, 16'd500, 8'h44, 1'b0);
    query_element(6'd0, 16'd200, 1'b1);
  endtask

  // Counts above the store size search every template
  task automatic test_count_clamp();
    set_template_count(7'd127);
    send_beat(OP_LOAD, 6'd63, 6'd63, 16'hFFFF, 8'hFF, 1'b0);
    query_element(6'd0, SAMPLE_W'($urandom), 1'b1);
    query_element(6'd63, 16'h0000, 1'b1);
    set_template_count(7'd64);
    query_element(6'd63, 16'hFFFF, 1'b1);
  endtask

  // Template count raised and lowered inside one query
  task automatic test_count_midquery();
    set_template_count(7'd2);
    query_element(6'd0, SAMPLE_W'($urandom), 1'b0);
    set_template_count(7'd6);
    query_element(6'd1, SAMPLE_W'($urandom), 1'b1);
    query_element(6'd2, SAMPLE_W'($urandom), 1'b0);
    set_template_count(7'd1);
    query_element(6'd3, SAMPLE_W'($urandom), 1'b1);
  endtask

  // Repeat one far element until the sum saturates
  task automatic test_saturation();
    set_template_count(7'd1);
    send_beat(OP_LOAD, 6'd0, 6'd5, 16'h0000, 8'h77, 1'b0);
    query_element(6'd0, 16'hFFFF, 1'b0);
    for (int k = 0; k < 70; k++) query_element(6'd5, 16'hFFFF, 1'b0);
    query_element(6'd5, 16'hFFFF, 1'b1);
  endtask

  // Random loads and queries, mostly well-formed vectors of random content
  task automatic test_random(input int unsigned beats);
    int unsigned goal;
    int unsigned kind;
    int unsigned len;
    int unsigned split;
    goal = beats_sent + beats;
    while (beats_sent < goal) begin
      kind          = $urandom_range(0, 99);
      narrow_values = ($urandom_range(0, 3) == 0);
      if (kind < 6) begin
        set_template_count(pick_count());
      end else if (kind < 25) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          load_element(TIDX_W'($urandom), EIDX_W'($urandom), pick_sample(), 8'($urandom));
      end else if (kind < 85) begin
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        split = ($urandom_range(0, 19) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
        for (int k = 0; k < len; k++) begin
          if (split != 0 && k == split) set_template_count(pick_count());
          query_element(EIDX_W'(k), pick_sample(), k == len - 1);
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          query_element(EIDX_W'($urandom), pick_sample(), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    operation_i      = OP_LOAD;
    template_index_i = '0;
    element_index_i  = '0;
    sample_value_i   = '0;
    class_label_i    = '0;
    last_element_i   = 1'b0;
    template_count   = '0;
    narrow_values    = 1'b0;
    foreach (distance_acc[i]) distance_acc[i] = '0;
    send_idle_pct    = 13;
    recv_idle_pct    = 53;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_no_templates();
    test_extremes();
    test_ties();
    test_count_clamp();
    test_count_midquery();
    test_random(700);
    test_saturation();
    send_idle_pct = 53;
    recv_idle_pct = 13;
    test_random(650);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(650);

    // Drain outstanding results, then let the pipeline settle
    in_valid_i <= 1'b0;
    while (nearest_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    mismatches += nearest_q.size();

    $display("Covered %0d load beats, %0d query beats, %0d count writes",
             load_beats, query_beats, count_writes);
    $display("Checked %0d results: %0d with no template, %0d saturated, %0d mismatches",
             results_seen, empty_results, saturated_results, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
